// ===== hw/rtl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI event parser package
// Result record, result kinds, error codes and message size decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NO_STATUS = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_OVERLONG  = 2'd2;

  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_SYX_END = 8'hF7;
  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] STATUS_CHANNEL = 8'h80;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  status;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [7:0]  meta_kind;
    logic [27:0] delta_ticks;
    logic [31:0] absolute_ticks;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_count(input logic [7:0] s);
    logic [1:0] n;
    if (s < STATUS_SYSEX) begin
      n = (s[7:4] inside {4'hC, 4'hD}) ? 2'd1 : 2'd2;
    end else if (s inside {8'hF1, 8'hF3}) begin
      n = 2'd1;
    end else if (s == 8'hF2) begin
      n = 2'd2;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/midi_event_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI event byte parser
// Usage notes:
// Bytes of a MIDI file event stream enter on the input channel (in_valid,
// in_ready, byte_value, stream_end), one per transfer. Each byte updates the
// parser state and yields at most one result on the output channel
// (out_valid, out_ready and the result fields): an event header, a payload
// byte of a sysex or meta event, or an error. Bytes that finish nothing
// give no result.
// A byte is captured in an input register, processed once the output register
// can take its result, and its result is then held in the output register.
// One byte is taken in every cycle while the receiver does not stall; the rate
// is set by the per-byte state update in the parser core.
// When the receiver stalls, the held result stays put, the input register
// keeps the next byte and in_ready falls once both are occupied.
// file_mode is written with cfg_wr_en and cfg_wr_data; the user must do this
// only while the block is idle, which the block does not enforce. Reset sets
// file_mode to 1, clears the time base and running status and goes to PH_DELTA.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_event_byte_parser_unit #(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  byte_value,
  input  wire         stream_end,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  status,
  output logic [7:0]  data_first,
  output logic [7:0]  data_second,
  output logic [7:0]  meta_kind,
  output logic [27:0] delta_ticks,
  output logic [31:0] absolute_ticks,
  output logic [27:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic [1:0]  error_code,
  output logic        last
);

  import mep_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_end;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= byte_value;
      in_end  <= stream_end;
    end
  end

  mep_parse_core #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step_valid (advance),
    .step_byte  (in_byte),
    .step_end   (in_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result_kind    = out_res.result_kind;
  assign status         = out_res.status;
  assign data_first     = out_res.data_first;
  assign data_second    = out_res.data_second;
  assign meta_kind      = out_res.meta_kind;
  assign delta_ticks    = out_res.delta_ticks;
  assign absolute_ticks = out_res.absolute_ticks;
  assign payload_length = out_res.payload_length;
  assign payload_byte   = out_res.payload_byte;
  assign error_code     = out_res.error_code;
  assign last           = out_res.last;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_ERROR) |-> (last && payload_byte == 8'd0))
    else $error("Error result without last mark or with payload.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_length != 28'd0) |-> (result_kind == KIND_HEADER && !last))
    else $error("Payload length on a result that is not an open meta header.");

  assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> in_vld)
    else $error("Held input byte was dropped.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Stalled result was lost.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mep_parse_core.sv =====
// ----------------------------------------------------------------------------
// MIDI event parser core
// Parser state, the file mode register and the per-byte next-state and
// result logic. One byte is consumed in every cycle that step_valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_parse_core #(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wr_en,
  input  wire                   cfg_wr_data,
  input  wire                   step_valid,
  input  wire  [7:0]            step_byte,
  input  wire                   step_end,
  output logic                  res_valid,
  output mep_pkg::result_t      res
);

  import mep_pkg::*;

  localparam int VLQ_W = $clog2(MAX_VLQ_BYTES + 1);

  localparam logic [2:0] PH_DELTA  = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_DATA1  = 3'd2;
  localparam logic [2:0] PH_DATA2  = 3'd3;
  localparam logic [2:0] PH_SYSEX  = 3'd4;
  localparam logic [2:0] PH_MTYPE  = 3'd5;
  localparam logic [2:0] PH_MLEN   = 3'd6;
  localparam logic [2:0] PH_MPAY   = 3'd7;

  logic             file_mode;
  logic [2:0]       phase, phase_next;
  logic [7:0]       running_status, running_status_next;
  logic [27:0]      delta_accum, delta_accum_next;
  logic [VLQ_W-1:0] vlq_count, vlq_count_next;
  logic [7:0]       held_data, held_data_next;
  logic [31:0]      absolute_time, absolute_time_next;
  logic [7:0]       meta_type_held, meta_type_held_next;
  logic [27:0]      payload_remaining, payload_remaining_next;

  logic [VLQ_W-1:0] cnt_inc;
  logic [27:0]      delta_base;
  logic [1:0]       dc_rs;
  logic [1:0]       dc_b;

  always_comb begin
    phase_next             = phase;
    running_status_next    = running_status;
    delta_accum_next       = delta_accum;
    vlq_count_next         = vlq_count;
    held_data_next         = held_data;
    absolute_time_next     = absolute_time;
    meta_type_held_next    = meta_type_held;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res                    = '0;
    cnt_inc                = vlq_count + VLQ_W'(1);
    delta_base             = (vlq_count == '0) ? 28'd0 : delta_accum;
    dc_rs                  = data_count(running_status);
    dc_b                   = data_count(step_byte);

    if (step_valid) begin
      if (step_end) begin
        if (phase != PH_DELTA || vlq_count != '0) begin
          phase_next     = PH_DELTA;
          vlq_count_next = '0;
          res_valid      = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code  = ERR_TRUNCATED;
          res.last        = 1'b1;
        end
      end else begin
        case (phase)
          PH_DELTA: begin
            delta_accum_next = {delta_base[20:0], step_byte[6:0]};
            if (step_byte[7]) begin
              if (cnt_inc >= VLQ_W'(MAX_VLQ_BYTES)) begin
                phase_next      = PH_DELTA;
                vlq_count_next  = '0;
                res_valid       = 1'b1;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_OVERLONG;
                res.last        = 1'b1;
              end else begin
                vlq_count_next = cnt_inc;
              end
            end else begin
              vlq_count_next     = '0;
              absolute_time_next = absolute_time + {4'd0, delta_accum_next};
              phase_next         = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (step_byte[7]) begin
              running_status_next = step_byte;
              meta_type_held_next = '0;
              if (step_byte == STATUS_SYSEX) begin
                phase_next      = PH_SYSEX;
                res_valid       = 1'b1;
                res.result_kind = KIND_HEADER;
              end else if (step_byte == STATUS_META && file_mode) begin
                phase_next = PH_MTYPE;
              end else if (dc_b == 2'd0) begin
                phase_next      = PH_DELTA;
                res_valid       = 1'b1;
                res.result_kind = KIND_HEADER;
                res.last        = 1'b1;
              end else begin
                phase_next = PH_DATA1;
              end
            end else if (running_status < STATUS_CHANNEL ||
                         running_status >= STATUS_SYSEX) begin
              phase_next      = PH_DELTA;
              vlq_count_next  = '0;
              res_valid       = 1'b1;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_NO_STATUS;
              res.last        = 1'b1;
            end else begin
              meta_type_held_next = '0;
              if (dc_rs == 2'd1) begin
                phase_next      = PH_DELTA;
                res_valid       = 1'b1;
                res.result_kind = KIND_HEADER;
                res.data_first  = step_byte;
                res.last        = 1'b1;
              end else begin
                held_data_next = step_byte;
                phase_next     = PH_DATA2;
              end
            end
          end
          PH_DATA1: begin
            if (dc_rs == 2'd1) begin
              phase_next      = PH_DELTA;
              res_valid       = 1'b1;
              res.result_kind = KIND_HEADER;
              res.data_first  = step_byte;
              res.last        = 1'b1;
            end else begin
              held_data_next = step_byte;
              phase_next     = PH_DATA2;
            end
          end
          PH_DATA2: begin
            phase_next      = PH_DELTA;
            res_valid       = 1'b1;
            res.result_kind = KIND_HEADER;
            res.data_first  = held_data;
            res.data_second = step_byte;
            res.last        = 1'b1;
          end
          PH_SYSEX: begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = step_byte;
            if (step_byte == STATUS_SYX_END) begin
              phase_next = PH_DELTA;
              res.last   = 1'b1;
            end
          end
          PH_MTYPE: begin
            meta_type_held_next    = step_byte;
            payload_remaining_next = '0;
            vlq_count_next         = '0;
            phase_next             = PH_MLEN;
          end
          PH_MLEN: begin
            payload_remaining_next = {payload_remaining[20:0], step_byte[6:0]};
            if (step_byte[7]) begin
              if (cnt_inc >= VLQ_W'(MAX_VLQ_BYTES)) begin
                phase_next      = PH_DELTA;
                vlq_count_next  = '0;
                res_valid       = 1'b1;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_OVERLONG;
                res.last        = 1'b1;
              end else begin
                vlq_count_next = cnt_inc;
              end
            end else begin
              vlq_count_next  = '0;
              res_valid       = 1'b1;
              res.result_kind = KIND_HEADER;
              if (payload_remaining_next == 28'd0) begin
                phase_next = PH_DELTA;
                res.last   = 1'b1;
              end else begin
                phase_next         = PH_MPAY;
                res.payload_length = payload_remaining_next;
              end
            end
          end
          default: begin
            payload_remaining_next = payload_remaining - 28'd1;
            res_valid              = 1'b1;
            res.result_kind        = KIND_PAYLOAD;
            res.payload_byte       = step_byte;
            if (payload_remaining_next == 28'd0) begin
              phase_next = PH_DELTA;
              res.last   = 1'b1;
            end
          end
        endcase
      end
    end

    res.status         = running_status_next;
    res.delta_ticks    = delta_accum_next;
    res.absolute_ticks = absolute_time_next;
    res.meta_kind      = (res.result_kind == KIND_ERROR) ? 8'd0 : meta_type_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_mode         <= 1'b1;
      phase             <= PH_DELTA;
      running_status    <= '0;
      delta_accum       <= '0;
      vlq_count         <= '0;
      held_data         <= '0;
      absolute_time     <= '0;
      meta_type_held    <= '0;
      payload_remaining <= '0;
    end else begin
      if (cfg_wr_en) begin
        file_mode <= cfg_wr_data;
      end
      phase             <= phase_next;
      running_status    <= running_status_next;
      delta_accum       <= delta_accum_next;
      vlq_count         <= vlq_count_next;
      held_data         <= held_data_next;
      absolute_time     <= absolute_time_next;
      meta_type_held    <= meta_type_held_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

`default_nettype wire
